>>> design/mse_pkg.sv
// Shared types and encodings for the MIPS-subset execute core.
package mse_pkg;

  localparam int unsigned PC_W   = 12;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned REG_W  = 5;

  // Primary opcodes.
  localparam logic [5:0] OP_RTYPE = 6'b000000;
  localparam logic [5:0] OP_J     = 6'b000010;
  localparam logic [5:0] OP_JAL   = 6'b000011;
  localparam logic [5:0] OP_BEQ   = 6'b000100;
  localparam logic [5:0] OP_BNE   = 6'b000101;
  localparam logic [5:0] OP_BLEZ  = 6'b000110;
  localparam logic [5:0] OP_BGTZ  = 6'b000111;
  localparam logic [5:0] OP_LW    = 6'b100011;
  localparam logic [5:0] OP_SW    = 6'b101011;

  // Function codes of R-type instructions.
  localparam logic [5:0] FN_SLL = 6'b000000;
  localparam logic [5:0] FN_SRL = 6'b000010;
  localparam logic [5:0] FN_JR  = 6'b001000;
  localparam logic [5:0] FN_ADD = 6'b100000;
  localparam logic [5:0] FN_SUB = 6'b100010;

  localparam logic [REG_W-1:0] REG_ZERO = 5'd0;
  localparam logic [REG_W-1:0] REG_LINK = 5'd31;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_HALT       = 3'd1,
    ST_BAD_OPCODE = 3'd2,
    ST_BAD_FUNCT  = 3'd3,
    ST_ADDR_FAULT = 3'd4
  } status_t;

endpackage

>>> design/mse_if.sv
// Valid/ready channel interfaces for instruction words and execution results.
interface mse_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink   (input valid, input instruction, output ready);
endinterface

interface mse_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] next_pc;
  logic        reg_write;
  logic [4:0]  dest_reg;
  logic [31:0] dest_value;
  logic        mem_write;
  logic [2:0]  status;

  modport source (output valid, output next_pc, output reg_write, output dest_reg,
                  output dest_value, output mem_write, output status, input ready);
  modport sink   (input valid, input next_pc, input reg_write, input dest_reg,
                  input dest_value, input mem_write, input status, output ready);
endinterface

>>> design/mips_subset_execute_core.sv
// Top level of the MIPS-subset execute core: register file, data memory and pc.
//
//  Channel  | Direction | Handshake           | Word carried
//  ---------+-----------+---------------------+-----------------------------------------
//  in_chan  | in        | valid/ready         | one 32-bit instruction word
//  out_chan | out       | valid/ready         | next_pc, register write, memory write, status
//
// One instruction is accepted per cycle unless the output stalls or the clearing pass runs;
// it waits in stage one, and its result word is offered from the output register.
// The rate is set by the execute stage, which finishes one instruction per cycle unless the
// output stalls, using the data memory port and the register file write port at most once.
// After reset a clearing pass zeroes the data memory, one word per cycle, over all MEM_WORDS
// words; no instruction is accepted during it.
// A stalled result stays in the output register; one more instruction can wait in the
// execute stage behind it; input ready falls only when both are occupied or during clearing.
module mips_subset_execute_core #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  mse_in_if.sink     in_chan,
  mse_out_if.source  out_chan
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned PW = mse_pkg::PC_W;
  localparam int unsigned WW = mse_pkg::WORD_W;
  localparam int unsigned RW = mse_pkg::REG_W;

  // ---------------------------------------------------------------------------------------
  // Clearing pass over the data memory after reset.
  // ---------------------------------------------------------------------------------------
  logic          clr_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Pipeline control. Stage one executes, stage two is the output register.
  // ---------------------------------------------------------------------------------------
  logic s1_valid_r;
  logic s2_valid_r;
  logic s2_new_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv        = s1_valid_r && (!s2_valid_r || out_chan.ready);
  assign in_chan.ready = !clr_r && (!s1_valid_r || s1_adv);
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_new_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        s2_valid_r <= 1'b0;
      end
      s2_new_r <= s1_adv;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage two state, declared here because the register bypass reads it.
  // ---------------------------------------------------------------------------------------
  logic [PW-1:0] s2_next_pc_r;
  logic          s2_wr_r;
  logic [RW-1:0] s2_dreg_r;
  logic [WW-1:0] s2_val_r;
  logic          s2_load_r;
  logic          s2_mw_r;
  mse_pkg::status_t s2_status_r;
  logic [WW-1:0] dm_rdata_r;

  // The register write of the item in the output register happens in its first cycle there.
  // A load takes its value straight from the data memory read register.
  logic          wr_now;
  logic [WW-1:0] wr_val;

  assign wr_now = s2_valid_r && s2_new_r && s2_wr_r;
  assign wr_val = s2_load_r ? dm_rdata_r : s2_val_r;

  // ---------------------------------------------------------------------------------------
  // Register file: two read ports addressed at acceptance, one write port. An entry not
  // written since reset reads as zero through its valid bit.
  // ---------------------------------------------------------------------------------------
  logic [WW-1:0] rf_mem [32];
  logic [31:0]   rf_vld_r;
  logic [WW-1:0] rf_a_r;
  logic [WW-1:0] rf_b_r;
  logic          vld_a_r;
  logic          vld_b_r;
  logic [RW-1:0] in_rs;
  logic [RW-1:0] in_rt;

  assign in_rs = in_chan.instruction[25:21];
  assign in_rt = in_chan.instruction[20:16];

  always_ff @(posedge clk) begin
    if (wr_now) begin
      rf_mem[s2_dreg_r] <= wr_val;
    end
    if (in_acc) begin
      rf_a_r <= rf_mem[in_rs];
      rf_b_r <= rf_mem[in_rt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (wr_now) begin
      rf_vld_r[s2_dreg_r] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage one registers and the bypass that keeps its operands current. A write landing at
  // the acceptance edge, or while the instruction waits, is caught in the forward registers.
  // ---------------------------------------------------------------------------------------
  logic [WW-1:0] s1_ins_r;
  logic          fwd_a_r;
  logic          fwd_b_r;
  logic [WW-1:0] fwd_a_val_r;
  logic [WW-1:0] fwd_b_val_r;
  logic [RW-1:0] s1_rs;
  logic [RW-1:0] s1_rt;
  logic          s1_hold;

  assign s1_rs   = s1_ins_r[25:21];
  assign s1_rt   = s1_ins_r[20:16];
  assign s1_hold = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ins_r <= in_chan.instruction;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_a_r <= 1'b0;
      fwd_b_r <= 1'b0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (in_acc) begin
      fwd_a_r <= wr_now && (s2_dreg_r == in_rs);
      fwd_b_r <= wr_now && (s2_dreg_r == in_rt);
      vld_a_r <= rf_vld_r[in_rs];
      vld_b_r <= rf_vld_r[in_rt];
    end else if (s1_hold && wr_now) begin
      if (s2_dreg_r == s1_rs) begin
        fwd_a_r <= 1'b1;
      end
      if (s2_dreg_r == s1_rt) begin
        fwd_b_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_now && ((in_acc && s2_dreg_r == in_rs) || (s1_hold && s2_dreg_r == s1_rs))) begin
      fwd_a_val_r <= wr_val;
    end
    if (wr_now && ((in_acc && s2_dreg_r == in_rt) || (s1_hold && s2_dreg_r == s1_rt))) begin
      fwd_b_val_r <= wr_val;
    end
  end

  // Operands: register zero, then the write in flight, then a caught write, then the file.
  logic [WW-1:0] opa;
  logic [WW-1:0] opb;

  always_comb begin
    if (s1_rs == mse_pkg::REG_ZERO) begin
      opa = '0;
    end else if (wr_now && s2_dreg_r == s1_rs) begin
      opa = wr_val;
    end else if (fwd_a_r) begin
      opa = fwd_a_val_r;
    end else if (vld_a_r) begin
      opa = rf_a_r;
    end else begin
      opa = '0;
    end
  end

  always_comb begin
    if (s1_rt == mse_pkg::REG_ZERO) begin
      opb = '0;
    end else if (wr_now && s2_dreg_r == s1_rt) begin
      opb = wr_val;
    end else if (fwd_b_r) begin
      opb = fwd_b_val_r;
    end else if (vld_b_r) begin
      opb = rf_b_r;
    end else begin
      opb = '0;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Execute. The pc register always holds the pc of the instruction in stage one, because
  // stage one handles instructions strictly one at a time and in order.
  // ---------------------------------------------------------------------------------------
  logic [PW-1:0] pc_r;
  logic [5:0]    op;
  logic [5:0]    fn;
  logic [RW-1:0] s1_rd;
  logic [4:0]    shamt;
  logic [WW-1:0] off;
  logic [PW-1:0] pc_inc;
  logic [PW-1:0] br_tgt;
  logic [WW-1:0] addr;
  logic          addr_ok;

  assign op      = s1_ins_r[31:26];
  assign fn      = s1_ins_r[5:0];
  assign s1_rd   = s1_ins_r[15:11];
  assign shamt   = s1_ins_r[10:6];
  assign off     = {{16{s1_ins_r[15]}}, s1_ins_r[15:0]};
  assign pc_inc  = pc_r + 1'b1;
  assign br_tgt  = pc_r + off[PW-1:0];
  assign addr    = opa + off;
  assign addr_ok = !addr[WW-1] && (addr < WW'(MEM_WORDS));

  logic [PW-1:0]    x_next;
  logic             x_wr;
  logic [RW-1:0]    x_dreg;
  logic [WW-1:0]    x_val;
  logic             x_load;
  logic             x_store;
  mse_pkg::status_t x_status;

  always_comb begin
    x_next   = pc_inc;
    x_wr     = 1'b0;
    x_dreg   = mse_pkg::REG_ZERO;
    x_val    = '0;
    x_load   = 1'b0;
    x_store  = 1'b0;
    x_status = mse_pkg::ST_OK;
    if (s1_ins_r == '0) begin
      x_status = mse_pkg::ST_HALT;
      x_next   = pc_r;
    end else begin
      unique case (op)
        mse_pkg::OP_RTYPE: begin
          unique case (fn)
            mse_pkg::FN_SLL: begin
              x_wr = 1'b1; x_dreg = s1_rd; x_val = opb << shamt;
            end
            mse_pkg::FN_SRL: begin
              x_wr = 1'b1; x_dreg = s1_rd; x_val = opb >> shamt;
            end
            mse_pkg::FN_ADD: begin
              x_wr = 1'b1; x_dreg = s1_rd; x_val = opa + opb;
            end
            mse_pkg::FN_SUB: begin
              x_wr = 1'b1; x_dreg = s1_rd; x_val = opa - opb;
            end
            mse_pkg::FN_JR: begin
              x_next = opa[PW-1:0];
            end
            default: begin
              x_status = mse_pkg::ST_BAD_FUNCT;
            end
          endcase
        end
        mse_pkg::OP_LW: begin
          if (!addr_ok) begin
            x_status = mse_pkg::ST_ADDR_FAULT;
          end else begin
            x_wr = 1'b1; x_dreg = s1_rt; x_load = 1'b1;
          end
        end
        mse_pkg::OP_SW: begin
          if (!addr_ok) begin
            x_status = mse_pkg::ST_ADDR_FAULT;
          end else begin
            x_store = 1'b1;
          end
        end
        mse_pkg::OP_BEQ: begin
          if (opa == opb) x_next = br_tgt;
        end
        mse_pkg::OP_BNE: begin
          if (opa != opb) x_next = br_tgt;
        end
        mse_pkg::OP_BLEZ: begin
          if (opa[WW-1] || opa == '0) x_next = br_tgt;
        end
        mse_pkg::OP_BGTZ: begin
          if (!opa[WW-1] && opa != '0) x_next = br_tgt;
        end
        mse_pkg::OP_J: begin
          x_next = s1_ins_r[PW-1:0];
        end
        mse_pkg::OP_JAL: begin
          x_wr   = 1'b1;
          x_dreg = mse_pkg::REG_LINK;
          x_val  = {{(WW-PW){1'b0}}, pc_inc};
          x_next = s1_ins_r[PW-1:0];
        end
        default: begin
          x_status = mse_pkg::ST_BAD_OPCODE;
        end
      endcase
    end
    // Register zero is never written; a discarded write reports nothing.
    if (x_dreg == mse_pkg::REG_ZERO) begin
      x_wr = 1'b0;
    end
    if (!x_wr) begin
      x_dreg = mse_pkg::REG_ZERO;
      x_val  = '0;
      x_load = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (s1_adv) begin
      pc_r <= x_next;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Data memory: one port, used by the clearing pass or by the instruction in stage one.
  // ---------------------------------------------------------------------------------------
  logic [WW-1:0] dm_mem [MEM_WORDS];
  logic          dm_we;
  logic          dm_re;
  logic [AW-1:0] dm_waddr;
  logic [WW-1:0] dm_wdata;

  assign dm_we    = clr_r || (s1_adv && x_store);
  assign dm_re    = s1_adv && x_load;
  assign dm_waddr = clr_r ? clr_cnt_r : addr[AW-1:0];
  assign dm_wdata = clr_r ? '0 : opb;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dm_mem[dm_waddr] <= dm_wdata;
    end
    if (dm_re) begin
      dm_rdata_r <= dm_mem[addr[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_next_pc_r <= x_next;
      s2_wr_r      <= x_wr;
      s2_dreg_r    <= x_dreg;
      s2_val_r     <= x_val;
      s2_load_r    <= x_load;
      s2_mw_r      <= x_store;
      s2_status_r  <= x_status;
    end
  end

  assign out_chan.valid      = s2_valid_r;
  assign out_chan.next_pc    = s2_next_pc_r;
  assign out_chan.reg_write  = s2_wr_r;
  assign out_chan.dest_reg   = s2_dreg_r;
  assign out_chan.dest_value = wr_val;
  assign out_chan.mem_write  = s2_mw_r;
  assign out_chan.status     = s2_status_r;

  // ---------------------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------------------

  // An instruction waiting in stage one must not move the pc.
  a_pc_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_hold |=> $stable(pc_r))
    else $error("pc changed while stage one was stalled");

  // A halt leaves the pc where it was.
  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_ins_r == '0) |=> (pc_r == $past(pc_r)))
    else $error("halt moved the pc");

  // A reported write never targets register zero, and a result without one reports zeros.
  a_wr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_wr_r ? (s2_dreg_r != mse_pkg::REG_ZERO)
                            : (s2_dreg_r == mse_pkg::REG_ZERO && wr_val == '0)))
    else $error("inconsistent register write fields");

  // A store only reports success, and never coincides with a register write.
  a_store_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_mw_r) |-> (s2_status_r == mse_pkg::ST_OK && !s2_wr_r))
    else $error("store reported with a bad status or a register write");

  // No instruction enters stage one while the data memory is being cleared.
  a_no_issue_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (!s1_valid_r && !s2_valid_r))
    else $error("pipeline occupied during the clearing pass");

endmodule

>>> sim/mips_subset_execute_monitor.sv
// Monitor for the execute core: predicts every result word and compares it with the DUT.
module mips_subset_execute_monitor #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  mse_in_if           in_mon,
  mse_out_if          out_mon,
  output int unsigned mismatch_count,
  output int unsigned results_awaited
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef struct packed {
    logic [mse_pkg::PC_W-1:0]   next_pc;
    logic                       reg_write;
    logic [mse_pkg::REG_W-1:0]  dest_reg;
    logic [mse_pkg::WORD_W-1:0] dest_value;
    logic                       mem_write;
    mse_pkg::status_t           status;
  } exec_result_t;

  // Architectural state as the core should hold it.
  logic [mse_pkg::WORD_W-1:0] gpr [32];
  logic [mse_pkg::WORD_W-1:0] dmem [MEM_WORDS];
  logic [mse_pkg::PC_W-1:0]   pc_q;

  exec_result_t pending_results [$];

  function automatic logic [mse_pkg::WORD_W-1:0] read_gpr(
      input logic [mse_pkg::REG_W-1:0] idx);
    return (idx == mse_pkg::REG_ZERO) ? '0 : gpr[idx];
  endfunction

  // Executes one instruction word against the predicted state and returns its result word.
  function automatic exec_result_t execute_instruction(
      input logic [mse_pkg::WORD_W-1:0] ins);
    exec_result_t               res;
    logic [5:0]                 op;
    logic [5:0]                 fn;
    logic [mse_pkg::REG_W-1:0]  rs;
    logic [mse_pkg::REG_W-1:0]  rt;
    logic [mse_pkg::REG_W-1:0]  rd;
    logic [4:0]                 sh;
    logic [mse_pkg::WORD_W-1:0] a;
    logic [mse_pkg::WORD_W-1:0] b;
    logic [mse_pkg::WORD_W-1:0] off;
    logic [mse_pkg::WORD_W-1:0] addr;
    logic [mse_pkg::PC_W-1:0]   cur;
    logic                       taken;
    logic                       wr;
    op    = ins[31:26];
    rs    = ins[25:21];
    rt    = ins[20:16];
    rd    = ins[15:11];
    sh    = ins[10:6];
    fn    = ins[5:0];
    cur   = pc_q;
    a     = read_gpr(rs);
    b     = read_gpr(rt);
    off   = {{16{ins[15]}}, ins[15:0]};
    taken = 1'b0;
    wr    = 1'b0;
    res   = '0;
    res.status  = mse_pkg::ST_OK;
    res.next_pc = cur + 12'd1;
    if (ins == '0) begin
      res.status  = mse_pkg::ST_HALT;
      res.next_pc = cur;
    end else begin
      case (op)
        mse_pkg::OP_RTYPE: begin
          case (fn)
            mse_pkg::FN_SLL: begin
              wr = 1'b1;
              res.dest_reg   = rd;
              res.dest_value = b << sh;
            end
            mse_pkg::FN_SRL: begin
              wr = 1'b1;
              res.dest_reg   = rd;
              res.dest_value = b >> sh;
            end
            mse_pkg::FN_ADD: begin
              wr = 1'b1;
              res.dest_reg   = rd;
              res.dest_value = a + b;
            end
            mse_pkg::FN_SUB: begin
              wr = 1'b1;
              res.dest_reg   = rd;
              res.dest_value = a - b;
            end
            mse_pkg::FN_JR: res.next_pc = a[mse_pkg::PC_W-1:0];
            default: res.status = mse_pkg::ST_BAD_FUNCT;
          endcase
        end
        mse_pkg::OP_LW, mse_pkg::OP_SW: begin
          addr = a + off;
          if (addr[31] || addr >= MEM_WORDS) begin
            res.status = mse_pkg::ST_ADDR_FAULT;
          end else if (op == mse_pkg::OP_LW) begin
            wr = 1'b1;
            res.dest_reg   = rt;
            res.dest_value = dmem[addr[AW-1:0]];
          end else begin
            dmem[addr[AW-1:0]] = b;
            res.mem_write      = 1'b1;
          end
        end
        mse_pkg::OP_BEQ, mse_pkg::OP_BNE, mse_pkg::OP_BLEZ, mse_pkg::OP_BGTZ: begin
          case (op)
            mse_pkg::OP_BEQ:  taken = (a == b);
            mse_pkg::OP_BNE:  taken = (a != b);
            mse_pkg::OP_BLEZ: taken = ($signed(a) <= 0);
            default:          taken = ($signed(a) > 0);
          endcase
          if (taken) res.next_pc = cur + off[mse_pkg::PC_W-1:0];
        end
        mse_pkg::OP_J, mse_pkg::OP_JAL: begin
          if (op == mse_pkg::OP_JAL) begin
            wr = 1'b1;
            res.dest_reg   = mse_pkg::REG_LINK;
            res.dest_value = {20'd0, cur + 12'd1};
          end
          res.next_pc = ins[mse_pkg::PC_W-1:0];
        end
        default: res.status = mse_pkg::ST_BAD_OPCODE;
      endcase
    end
    if (wr && res.dest_reg != mse_pkg::REG_ZERO) begin
      gpr[res.dest_reg] = res.dest_value;
      res.reg_write     = 1'b1;
    end else begin
      res.dest_reg   = '0;
      res.dest_value = '0;
    end
    pc_q = res.next_pc;
    return res;
  endfunction

  task automatic compare_field(input string field,
                               input logic [mse_pkg::WORD_W-1:0] expected_v,
                               input logic [mse_pkg::WORD_W-1:0] actual_v);
    if (actual_v !== expected_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, expected_v, actual_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    exec_result_t exp_res;
    exec_result_t new_res;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
      pc_q = '0;
      pending_results.delete();
      mismatch_count = 0;
    end else begin
      // Results are compared before new words are predicted; the core's latency means a
      // result can never belong to the word accepted at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with no instruction outstanding: next_pc 0x%0h status %0d",
                 out_mon.next_pc, out_mon.status);
          mismatch_count++;
        end else begin
          exp_res = pending_results.pop_front();
          compare_field("next_pc", 32'(exp_res.next_pc), 32'(out_mon.next_pc));
          compare_field("reg_write", 32'(exp_res.reg_write), 32'(out_mon.reg_write));
          compare_field("dest_reg", 32'(exp_res.dest_reg), 32'(out_mon.dest_reg));
          compare_field("dest_value", exp_res.dest_value, out_mon.dest_value);
          compare_field("mem_write", 32'(exp_res.mem_write), 32'(out_mon.mem_write));
          compare_field("status", 32'(exp_res.status), 32'(out_mon.status));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        new_res = execute_instruction(in_mon.instruction);
        pending_results.insert(pending_results.size(), new_res);
      end
    end
    results_awaited = pending_results.size();
  end

endmodule

>>> sim/mips_subset_execute_core_test.sv
// Top of the execute core testbench: clock, reset, instruction stimulus and the verdict.
module mips_subset_execute_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_WORDS = 4096;

  // The clearing pass after reset keeps the input closed until all MEM_WORDS data words
  // are zero, so the watchdog must tolerate that whole pass without a handshake.
  localparam int unsigned WATCHDOG_LIMIT = 5 * MEM_WORDS;

  // Words per random phase; eight phases give roughly 850 random instructions.
  localparam int unsigned PHASE_WORDS = 106;

  // Encodings that the core does not support, used to provoke the error statuses.
  localparam logic [5:0]  FN_UNUSED = 6'b000001;
  localparam logic [5:0]  OP_UNUSED = 6'b111111;
  localparam logic [31:0] HALT_WORD = 32'h0000_0000;

  // Registers given fixed roles in the directed sequence.
  localparam logic [mse_pkg::REG_W-1:0] R_SUM      = 5'd1;
  localparam logic [mse_pkg::REG_W-1:0] R_ALL_ONES = 5'd2;
  localparam logic [mse_pkg::REG_W-1:0] R_SIGN     = 5'd3;
  localparam logic [mse_pkg::REG_W-1:0] R_UNIT     = 5'd4;
  localparam logic [mse_pkg::REG_W-1:0] R_LOADED   = 5'd5;
  localparam logic [mse_pkg::REG_W-1:0] R_LOADED_B = 5'd6;

  logic clk;
  logic rst_n;

  mse_in_if  in_chan ();
  mse_out_if out_chan ();

  int unsigned mismatch_count;
  int unsigned results_awaited;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned idle_pct;
  int unsigned stall_pct;

  int unsigned quiet_cycles;

  mips_subset_execute_core #(.MEM_WORDS(MEM_WORDS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  mips_subset_execute_monitor #(.MEM_WORDS(MEM_WORDS)) execute_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .mismatch_count  (mismatch_count),
    .results_awaited (results_awaited)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Instruction word builders for the three MIPS formats.
  function automatic logic [31:0] r_word(input logic [mse_pkg::REG_W-1:0] rs,
                                         input logic [mse_pkg::REG_W-1:0] rt,
                                         input logic [mse_pkg::REG_W-1:0] rd,
                                         input logic [4:0] sh, input logic [5:0] fn);
    return {mse_pkg::OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_word(input logic [5:0] op,
                                         input logic [mse_pkg::REG_W-1:0] rs,
                                         input logic [mse_pkg::REG_W-1:0] rt,
                                         input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] j_word(input logic [5:0] op, input logic [25:0] target);
    return {op, target};
  endfunction

  // Random instruction mix. Most words are well formed so that the register file and the
  // data memory fill with varied values; loads and stores mostly go through register zero
  // with a small offset, so that stores are read back. The rest is bad encodings and noise.
  function automatic logic [31:0] make_random_instruction();
    int unsigned               pick;
    logic [5:0]                op;
    logic [5:0]                fn;
    logic [mse_pkg::REG_W-1:0] rs;
    logic [15:0]               imm;
    pick = $urandom_range(99);
    rs   = 5'($urandom);
    imm  = 16'($urandom);
    if (pick < 30) begin
      case ($urandom_range(4))
        0:       fn = mse_pkg::FN_SLL;
        1:       fn = mse_pkg::FN_SRL;
        2:       fn = mse_pkg::FN_ADD;
        3:       fn = mse_pkg::FN_SUB;
        default: fn = mse_pkg::FN_JR;
      endcase
      return r_word(rs, 5'($urandom), 5'($urandom), 5'($urandom), fn);
    end else if (pick < 55) begin
      op = ($urandom_range(1) == 0) ? mse_pkg::OP_LW : mse_pkg::OP_SW;
      if ($urandom_range(3) != 0) begin
        rs  = mse_pkg::REG_ZERO;
        imm = ($urandom_range(7) == 0) ? 16'($urandom_range(MEM_WORDS - 1))
                                       : 16'($urandom_range(63));
      end
      return i_word(op, rs, 5'($urandom), imm);
    end else if (pick < 72) begin
      case ($urandom_range(3))
        0:       op = mse_pkg::OP_BEQ;
        1:       op = mse_pkg::OP_BNE;
        2:       op = mse_pkg::OP_BLEZ;
        default: op = mse_pkg::OP_BGTZ;
      endcase
      return i_word(op, rs, 5'($urandom), imm);
    end else if (pick < 80) begin
      op = ($urandom_range(1) == 0) ? mse_pkg::OP_J : mse_pkg::OP_JAL;
      return j_word(op, 26'($urandom));
    end else if (pick < 84) begin
      return HALT_WORD;
    end else if (pick < 88) begin
      do fn = 6'($urandom);
      while (fn inside {mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_JR,
                        mse_pkg::FN_ADD, mse_pkg::FN_SUB});
      return r_word(rs, 5'($urandom), 5'($urandom), 5'($urandom), fn);
    end else if (pick < 92) begin
      do op = 6'($urandom);
      while (op inside {mse_pkg::OP_RTYPE, mse_pkg::OP_J, mse_pkg::OP_JAL, mse_pkg::OP_BEQ,
                        mse_pkg::OP_BNE, mse_pkg::OP_BLEZ, mse_pkg::OP_BGTZ,
                        mse_pkg::OP_LW, mse_pkg::OP_SW});
      return {op, 26'($urandom)};
    end
    return $urandom;
  endfunction

  // Offers one instruction word and returns once it has been accepted. Valid is left high,
  // so back-to-back words follow without a gap; the next call lowers it if it idles first.
  task automatic send_word(input logic [31:0] word);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.instruction <= word;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Result receiver: ready is redrawn at every falling edge.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: counts cycles without any handshake on either channel.
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned idle_by_phase  [4];
    int unsigned stall_by_phase [4];
    idle_by_phase  = '{0, 47, 0, 34};
    stall_by_phase = '{0, 0, 47, 34};
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.instruction = '0;
    idle_pct            = 0;
    stall_pct           = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed sequence. It builds a few known register values first, then walks through
    // the edge cases: shifts by the full amount, writes to register zero, the lowest and
    // highest data words, addresses just outside the memory on either side, taken
    // branches of every kind, untaken BNE and BGTZ, and pc wrap-around on jumps and links.
    // Halt at pc zero.
    send_word(HALT_WORD);
    // r31 = 1.
    send_word(j_word(mse_pkg::OP_JAL, 26'h000_0123));
    // 2.
    send_word(r_word(mse_pkg::REG_LINK, mse_pkg::REG_LINK, R_SUM, 5'd0, mse_pkg::FN_ADD));
    // All ones.
    send_word(r_word(mse_pkg::REG_ZERO, mse_pkg::REG_LINK, R_ALL_ONES, 5'd0,
                     mse_pkg::FN_SUB));
    // Sign bit only.
    send_word(r_word(R_SUM, R_ALL_ONES, R_SIGN, 5'd31, mse_pkg::FN_SLL));
    // Logical, gives 1.
    send_word(r_word(mse_pkg::REG_ZERO, R_ALL_ONES, R_UNIT, 5'd31, mse_pkg::FN_SRL));
    // Discarded write.
    send_word(r_word(mse_pkg::REG_LINK, mse_pkg::REG_LINK, mse_pkg::REG_ZERO, 5'd0,
                     mse_pkg::FN_ADD));
    // Top data word.
    send_word(i_word(mse_pkg::OP_SW, mse_pkg::REG_ZERO, R_ALL_ONES, 16'd4095));
    send_word(i_word(mse_pkg::OP_LW, mse_pkg::REG_ZERO, R_LOADED, 16'd4095));
    // 1 - 1 = word zero.
    send_word(i_word(mse_pkg::OP_SW, R_UNIT, R_SIGN, 16'hFFFF));
    send_word(i_word(mse_pkg::OP_LW, mse_pkg::REG_ZERO, R_LOADED_B, 16'd0));
    // Negative address.
    send_word(i_word(mse_pkg::OP_LW, mse_pkg::REG_ZERO, R_LOADED, 16'h8000));
    // One past the end.
    send_word(i_word(mse_pkg::OP_SW, mse_pkg::REG_ZERO, R_SIGN, 16'd4096));
    // Address -1.
    send_word(i_word(mse_pkg::OP_SW, R_ALL_ONES, R_SIGN, 16'd0));
    // Load into zero.
    send_word(i_word(mse_pkg::OP_LW, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 16'd0));
    // Taken backwards.
    send_word(i_word(mse_pkg::OP_BEQ, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 16'hFFFE));
    // Not taken.
    send_word(i_word(mse_pkg::OP_BNE, mse_pkg::REG_ZERO, mse_pkg::REG_ZERO, 16'h7FFF));
    // Taken forwards.
    send_word(i_word(mse_pkg::OP_BNE, R_ALL_ONES, mse_pkg::REG_ZERO, 16'h7FFF));
    // Negative, taken.
    send_word(i_word(mse_pkg::OP_BLEZ, R_ALL_ONES, R_SUM, 16'h0010));
    // Most negative.
    send_word(i_word(mse_pkg::OP_BGTZ, R_SIGN, R_UNIT, 16'h0010));
    // Taken; the far-back offset truncates to the same pc.
    send_word(i_word(mse_pkg::OP_BGTZ, R_UNIT, mse_pkg::REG_ZERO, 16'h8000));
    // pc to the last word.
    send_word(r_word(R_ALL_ONES, R_SUM, R_UNIT, 5'd7, mse_pkg::FN_JR));
    // Target all ones.
    send_word(j_word(mse_pkg::OP_JAL, 26'h3FF_FFFF));
    // Link wraps to zero.
    send_word(j_word(mse_pkg::OP_JAL, 26'h000_0000));
    send_word(r_word(R_SUM, R_SUM, R_SUM, 5'd0, FN_UNUSED));
    send_word({OP_UNUSED, 26'h3FF_FFFF});
    // Halt away from zero.
    send_word(HALT_WORD);

    // Random part, cycling twice through the idling and stalling mixes.
    for (int phase = 0; phase < 8; phase++) begin
      idle_pct  = idle_by_phase[phase % 4];
      stall_pct = stall_by_phase[phase % 4];
      for (int n = 0; n < PHASE_WORDS; n++) send_word(make_random_instruction());
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    stall_pct = 0;

    // Drain: the watchdog catches a core that stops producing results.
    while (results_awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0 && results_awaited == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
